[rtl/spmv_pkg.sv]
// Shared constants and codes for the sparse matrix-vector multiply block.
`default_nettype none

package spmv_pkg;

    // x store geometry
    localparam int X_DEPTH = 1024;
    localparam int XA_W    = $clog2(X_DEPTH);

    // Row counter width (wraps modulo 2^ROW_COUNT_BITS)
    localparam int ROW_COUNT_BITS = 16;

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int COL_W    = 10;
    localparam int VAL_W    = 32;
    localparam int ROWNUM_W = 16;
    localparam int ACC_W    = 64;
    localparam int CFG_IDX_W = 1;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NZ    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'd1;

    localparam logic [VAL_W-1:0] SCALE_RESET = 32'h0001_0000;

endpackage

`default_nettype wire

[rtl/spmv_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module spmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/csr_sparse_matrix_vector_multiply_top.sv]
// Top level of the streaming compressed-row sparse matrix-vector multiply block.
//
// Usage: load the dense vector x with FUNC_LOAD items (one per entry), then
// stream the matrix nonzeros of each row as FUNC_NZ items (column, value),
// and close every row with a FUNC_CLOSE item, which carries prior_y when
// accumulate mode is set. Each close gives one result item: the row number,
// the Q16.16 row result and a flag that tells whether anything clipped.
// Input and output channels use valid/ready; the configuration channel
// (mode, scale factor) is always ready; the user must write it only while idle,
// which the block does not enforce. A load writes the x store; a nonzero goes
// through x store read, one shared 33x33 multiplier and saturating accumulate;
// a close goes to the output register through magnitude, two partial products
// on the same multiplier, rounding and final saturation. An empty row gives
// zero, or prior_y in accumulate mode. Reset clears the accumulator, row
// counter and clip flag and resets the configuration; the x store is not
// cleared and holds garbage until written. A stalled receiver holds the
// result in the output register; further loads and nonzeros are still taken,
// and a later close waits in its last step until the output register frees up.
`default_nettype none

module csr_sparse_matrix_vector_multiply_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input item channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [spmv_pkg::FUNC_W-1:0]        i_func,
    input  wire logic [spmv_pkg::COL_W-1:0]         i_column_index,
    input  wire logic signed [spmv_pkg::VAL_W-1:0]  i_operand_value,
    input  wire logic signed [spmv_pkg::VAL_W-1:0]  i_prior_y,
    // result item channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [spmv_pkg::ROWNUM_W-1:0]           o_row_number,
    output logic signed [spmv_pkg::VAL_W-1:0]       o_y_value,
    output logic                                    o_saturated,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [spmv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [spmv_pkg::VAL_W-1:0]         i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_ACC  = 8'b0000_0100,
        S_ABS  = 8'b0000_1000,
        S_MLO  = 8'b0001_0000,
        S_MHI  = 8'b0010_0000,
        S_SUM  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic                             r_mode;
    logic signed [spmv_pkg::VAL_W-1:0] r_scale;

    // row state
    logic signed [spmv_pkg::ACC_W-1:0] r_acc;
    logic [spmv_pkg::ROW_COUNT_BITS-1:0] r_row;
    logic                             r_clip;

    // per-item working registers
    logic signed [spmv_pkg::VAL_W-1:0] r_op;
    logic                             r_in_range;
    logic signed [spmv_pkg::VAL_W-1:0] r_prior;
    logic signed [spmv_pkg::ACC_W-1:0] r_prod;
    logic [spmv_pkg::ACC_W-1:0]        r_plo;
    logic [spmv_pkg::ACC_W-1:0]        r_am;
    logic                             r_neg;
    logic [spmv_pkg::VAL_W-1:0]        r_sm;
    logic                             r_sneg;
    logic signed [41:0]               r_t;

    // output register
    logic                             r_out_valid;
    logic [spmv_pkg::ROWNUM_W-1:0]     r_out_row;
    logic signed [spmv_pkg::VAL_W-1:0] r_out_y;
    logic                             r_out_sat;

    logic in_acc;
    logic slot_free;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    // x store addressing: column range check against the store depth
    logic [spmv_pkg::XA_W+spmv_pkg::COL_W-1:0] col_ext;
    logic [spmv_pkg::XA_W-1:0]                 x_addr;
    logic                                      col_in_range;
    logic signed [spmv_pkg::VAL_W-1:0]         x_rdata;

    assign col_ext      = {{spmv_pkg::XA_W{1'b0}}, i_column_index};
    assign x_addr       = col_ext[spmv_pkg::XA_W-1:0];
    assign col_in_range = ({22'd0, i_column_index} < 32'(spmv_pkg::X_DEPTH));

    spmv_ram #(
        .WIDTH (spmv_pkg::VAL_W),
        .DEPTH (spmv_pkg::X_DEPTH)
    ) u_x_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_func == spmv_pkg::FUNC_LOAD) && col_in_range),
        .i_waddr (x_addr),
        .i_wdata (i_operand_value),
        .i_raddr (x_addr),
        .o_rdata (x_rdata)
    );

    // Shared multiplier: signed nonzero product, or unsigned partial products
    // of |acc| * |scale| on close.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    always_comb begin
        unique case (r_state)
            S_MLO: begin
                mul_a = {1'b0, r_am[31:0]};
                mul_b = {1'b0, r_sm};
            end
            S_MHI: begin
                mul_a = {1'b0, r_am[63:32]};
                mul_b = {1'b0, r_sm};
            end
            default: begin
                mul_a = {r_op[31], r_op};
                mul_b = r_in_range ? {x_rdata[31], x_rdata} : 33'sd0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // saturating accumulate
    logic signed [64:0] acc_sum;
    logic               acc_ovf;
    logic signed [63:0] acc_sat;
    assign acc_sum = {r_acc[63], r_acc} + {r_prod[63], r_prod};
    assign acc_ovf = acc_sum[64] != acc_sum[63];
    assign acc_sat = !acc_ovf ? acc_sum[63:0]
                   : (acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});

    // rounding to Q16.16 magnitude, both modes
    logic [63:0] lo_rnd;
    logic [63:0] q1;
    logic [64:0] q0_sum;
    logic [63:0] q_sel;
    logic [40:0] q_cap;
    logic        t_neg;
    assign lo_rnd = r_plo + 64'h0000_0000_8000_0000;
    assign q1     = r_prod + {32'd0, lo_rnd[63:32]};
    assign q0_sum = {1'b0, r_am} + 65'd32768;
    assign q_sel  = r_mode ? q1 : {15'd0, q0_sum[64:16]};
    assign q_cap  = (q_sel > 64'h0000_0100_0000_0000) ? {1'b1, 40'd0} : q_sel[40:0];
    assign t_neg  = r_mode ? (r_neg ^ r_sneg) : r_neg;

    // final add and saturation to 32 bits
    logic signed [42:0] y_sum;
    logic               y_clip;
    logic signed [31:0] y_sat;
    assign y_sum  = {r_t[41], r_t} + {{11{r_prior[31]}}, r_prior};
    assign y_clip = (y_sum[42:31] != {12{1'b0}}) && (y_sum[42:31] != {12{1'b1}});
    assign y_sat  = !y_clip ? y_sum[31:0]
                  : (y_sum[42] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}});

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_func == spmv_pkg::FUNC_NZ) begin
                        n_state = S_MUL;
                    end else if (i_func == spmv_pkg::FUNC_CLOSE) begin
                        n_state = S_ABS;
                    end
                end
            end
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = S_IDLE;
            S_ABS:   n_state = S_MLO;
            S_MLO:   n_state = S_MHI;
            S_MHI:   n_state = S_SUM;
            S_SUM:   n_state = S_FIN;
            S_FIN:   n_state = slot_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_scale     <= spmv_pkg::SCALE_RESET;
            r_acc       <= '0;
            r_row       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    spmv_pkg::CFG_MODE:  r_mode  <= i_cfg_data[0];
                    spmv_pkg::CFG_SCALE: r_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_ACC) begin
                r_acc <= acc_sat;
                if (acc_ovf) begin
                    r_clip <= 1'b1;
                end
            end
            if (r_state == S_FIN && slot_free) begin
                r_acc       <= '0;
                r_clip      <= 1'b0;
                r_row       <= r_row + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // row number out: low bits of the counter, zero-extended if narrower
    logic [spmv_pkg::ROW_COUNT_BITS+spmv_pkg::ROWNUM_W-1:0] row_ext;
    assign row_ext = {{spmv_pkg::ROWNUM_W{1'b0}}, r_row};

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[63:0];
        if (in_acc) begin
            r_op       <= i_operand_value;
            r_in_range <= col_in_range;
            r_prior    <= i_prior_y;
        end
        if (r_state == S_ABS) begin
            r_am   <= r_acc[63] ? (64'd0 - r_acc) : r_acc;
            r_neg  <= r_acc[63];
            r_sm   <= r_scale[31] ? (32'd0 - r_scale) : r_scale;
            r_sneg <= r_scale[31];
        end
        if (r_state == S_MHI) begin
            r_plo <= r_prod;
        end
        if (r_state == S_SUM) begin
            r_t <= t_neg ? -$signed({1'b0, q_cap}) : $signed({1'b0, q_cap});
            if (!r_mode) begin
                r_prior <= '0;
            end
        end
        if (r_state == S_FIN && slot_free) begin
            r_out_row <= row_ext[spmv_pkg::ROWNUM_W-1:0];
            r_out_y   <= y_sat;
            r_out_sat <= r_clip || y_clip;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row_number = r_out_row;
    assign o_y_value    = r_out_y;
    assign o_saturated  = r_out_sat;

endmodule

`default_nettype wire

[tb/spmv_row_checker.sv]
// Scoreboard that predicts and checks the row results of the sparse matrix-vector block.
`timescale 1ns / 1ps

module spmv_row_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_ready,
    input  wire logic [spmv_pkg::FUNC_W-1:0]        i_func,
    input  wire logic [spmv_pkg::COL_W-1:0]         i_column_index,
    input  wire logic signed [spmv_pkg::VAL_W-1:0]  i_operand_value,
    input  wire logic signed [spmv_pkg::VAL_W-1:0]  i_prior_y,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_ready,
    input  wire logic [spmv_pkg::ROWNUM_W-1:0]      i_row_number,
    input  wire logic signed [spmv_pkg::VAL_W-1:0]  i_y_value,
    input  wire logic                               i_saturated,
    input  wire logic                               i_cfg_valid,
    input  wire logic                               i_cfg_ready,
    input  wire logic [spmv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [spmv_pkg::VAL_W-1:0]         i_cfg_data,
    output int                                      o_fail_count,
    output int                                      o_rows_pending
);

    typedef struct packed {
        logic [spmv_pkg::ROWNUM_W-1:0] row;
        logic [spmv_pkg::VAL_W-1:0]    y;
        logic                          sat;
    } t_row_result;

    localparam logic signed [spmv_pkg::ACC_W-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [spmv_pkg::ACC_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [spmv_pkg::ACC_W-1:0] Y_MAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [spmv_pkg::ACC_W-1:0] Y_MIN   = 64'shFFFF_FFFF_8000_0000;
    localparam logic [95:0]                       MAG_CAP = 96'd1 << 40;

    logic [spmv_pkg::VAL_W-1:0]        x_mirror [0:spmv_pkg::X_DEPTH-1];
    logic signed [spmv_pkg::ACC_W-1:0] row_sum;
    logic [spmv_pkg::ROWNUM_W-1:0]     row_idx;
    logic                              clip_seen;
    logic                              mode_q;
    logic [spmv_pkg::VAL_W-1:0]        scale_q;
    t_row_result                       expected_rows [$];
    int                                mismatches = 0;
    int                                rows_waiting = 0;

    assign o_fail_count   = mismatches;
    assign o_rows_pending = rows_waiting;

    // Saturating multiply-accumulate; the top bit flags a clip.
    function automatic logic [spmv_pkg::ACC_W:0] mac_step(
            input logic signed [spmv_pkg::ACC_W-1:0] acc,
            input logic signed [spmv_pkg::VAL_W-1:0] a,
            input logic signed [spmv_pkg::VAL_W-1:0] b);
        logic signed [spmv_pkg::ACC_W-1:0] prod;
        logic [spmv_pkg::ACC_W:0]          wide;
        prod = a * b;
        wide = {acc[spmv_pkg::ACC_W-1], acc} + {prod[spmv_pkg::ACC_W-1], prod};
        case (wide[spmv_pkg::ACC_W:spmv_pkg::ACC_W-1])
            2'b01:   mac_step = {1'b1, SUM_MAX};
            2'b10:   mac_step = {1'b1, SUM_MIN};
            default: mac_step = {1'b0, wide[spmv_pkg::ACC_W-1:0]};
        endcase
    endfunction

    // Row result: round half away from zero on the magnitude, then saturate.
    function automatic t_row_result close_row(
            input logic signed [spmv_pkg::ACC_W-1:0] acc,
            input logic clip_in,
            input logic mode,
            input logic [spmv_pkg::VAL_W-1:0] scale,
            input logic signed [spmv_pkg::VAL_W-1:0] prior,
            input logic [spmv_pkg::ROWNUM_W-1:0] row);
        logic [spmv_pkg::ACC_W-1:0]        mag;
        logic [spmv_pkg::VAL_W-1:0]        smag;
        logic [95:0]                       prod;
        logic [95:0]                       q;
        logic                              neg;
        logic signed [spmv_pkg::ACC_W-1:0] t;
        logic signed [spmv_pkg::ACC_W-1:0] y_wide;
        t_row_result                       r;
        mag = acc[spmv_pkg::ACC_W-1] ? 64'd0 - acc : acc;
        if (!mode) begin
            q   = ({32'd0, mag} + 96'd32768) >> 16;
            neg = acc[spmv_pkg::ACC_W-1];
        end else begin
            smag = scale[spmv_pkg::VAL_W-1] ? 32'd0 - scale : scale;
            prod = {32'd0, mag} * {64'd0, smag};
            q    = (prod + 96'h8000_0000) >> 32;
            neg  = acc[spmv_pkg::ACC_W-1] ^ scale[spmv_pkg::VAL_W-1];
        end
        if (q > MAG_CAP) q = MAG_CAP;
        t = $signed(q[spmv_pkg::ACC_W-1:0]);
        if (neg) t = -t;
        y_wide = mode ? t + $signed({{32{prior[spmv_pkg::VAL_W-1]}}, prior}) : t;
        r.sat = clip_in;
        if (y_wide > Y_MAX) begin
            y_wide = Y_MAX;
            r.sat  = 1'b1;
        end else if (y_wide < Y_MIN) begin
            y_wide = Y_MIN;
            r.sat  = 1'b1;
        end
        r.row = row;
        r.y   = y_wide[spmv_pkg::VAL_W-1:0];
        close_row = r;
    endfunction

    always @(posedge i_clk) begin : track
        logic [spmv_pkg::ACC_W:0] mac;
        t_row_result              got;
        t_row_result              want;
        if (!i_rst_n) begin
            expected_rows.delete();
            row_sum   = '0;
            row_idx   = '0;
            clip_seen = 1'b0;
            mode_q    = 1'b0;
            scale_q   = spmv_pkg::SCALE_RESET;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    spmv_pkg::CFG_MODE:  mode_q  = i_cfg_data[0];
                    spmv_pkg::CFG_SCALE: scale_q = i_cfg_data;
                    default: ;
                endcase
            end
            // Results come out only after their close has been taken, so check first.
            if (i_out_valid && i_out_ready) begin
                got = {i_row_number, i_y_value, i_saturated};
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected row result: row %0d, y %h, saturated %0b",
                             $time, got.row, got.y, got.sat);
                    mismatches++;
                end else begin
                    want = expected_rows.pop_front();
                    if (got.row != want.row) begin
                        $display("%0t: row number: expected %0d, actual %0d",
                                 $time, want.row, got.row);
                        mismatches++;
                    end
                    if (got.y != want.y) begin
                        $display("%0t: y value of row %0d: expected %h, actual %h",
                                 $time, want.row, want.y, got.y);
                        mismatches++;
                    end
                    if (got.sat != want.sat) begin
                        $display("%0t: saturated flag of row %0d: expected %0b, actual %0b",
                                 $time, want.row, want.sat, got.sat);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_func)
                    spmv_pkg::FUNC_LOAD: begin
                        if (int'(i_column_index) < spmv_pkg::X_DEPTH)
                            x_mirror[i_column_index] = i_operand_value;
                    end
                    spmv_pkg::FUNC_NZ: begin
                        // an index beyond the store reads zero
                        if (int'(i_column_index) < spmv_pkg::X_DEPTH)
                            mac = mac_step(row_sum, i_operand_value, x_mirror[i_column_index]);
                        else
                            mac = mac_step(row_sum, i_operand_value, '0);
                        row_sum   = mac[spmv_pkg::ACC_W-1:0];
                        clip_seen = clip_seen | mac[spmv_pkg::ACC_W];
                    end
                    spmv_pkg::FUNC_CLOSE: begin
                        expected_rows.push_back(close_row(row_sum, clip_seen, mode_q,
                                                          scale_q, i_prior_y, row_idx));
                        row_sum   = '0;
                        clip_seen = 1'b0;
                        row_idx   = row_idx + 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        rows_waiting = expected_rows.size();
    end

endmodule

[tb/csr_sparse_matrix_vector_multiply_top_test.sv]
// Top of the testbench: stimulus, reset, watchdog and verdict for the SpMV block.
`timescale 1ns / 1ps

module csr_sparse_matrix_vector_multiply_top_test;

    // func code the block must take and ignore
    localparam logic [spmv_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
    // cycles with no item moving on any channel before the run is abandoned
    localparam int                          STALL_LIMIT = 5000;
    localparam logic [spmv_pkg::VAL_W-1:0]  Q_ONE   = 32'h0001_0000;
    localparam logic [spmv_pkg::VAL_W-1:0]  Q_HALF  = 32'h0000_8000;
    localparam logic [spmv_pkg::VAL_W-1:0]  VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [spmv_pkg::VAL_W-1:0]  VAL_MIN = 32'h8000_0000;

    logic                                 clk         = 1'b0;
    logic                                 rst_n       = 1'b0;
    logic                                 in_valid    = 1'b0;
    logic                                 in_ready;
    logic [spmv_pkg::FUNC_W-1:0]          in_func     = '0;
    logic [spmv_pkg::COL_W-1:0]           in_column   = '0;
    logic signed [spmv_pkg::VAL_W-1:0]    in_operand  = '0;
    logic signed [spmv_pkg::VAL_W-1:0]    in_prior    = '0;
    logic                                 out_valid;
    logic                                 out_ready   = 1'b0;
    logic [spmv_pkg::ROWNUM_W-1:0]        out_row;
    logic signed [spmv_pkg::VAL_W-1:0]    out_y;
    logic                                 out_sat;
    logic                                 cfg_valid   = 1'b0;
    logic                                 cfg_ready;
    logic [spmv_pkg::CFG_IDX_W-1:0]       cfg_index   = '0;
    logic [spmv_pkg::VAL_W-1:0]           cfg_data    = '0;

    int  fail_count;
    int  rows_pending;
    int  quiet_cycles = 0;
    int  rx_wait      = 0;
    bit  steady       = 1'b0;   // no idling on either side while set
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;
    bit  x_known [0:spmv_pkg::X_DEPTH-1];
    int  known_cols [$];

    always #5 clk = ~clk;

    csr_sparse_matrix_vector_multiply_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_func          (in_func),
        .i_column_index  (in_column),
        .i_operand_value (in_operand),
        .i_prior_y       (in_prior),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_row_number    (out_row),
        .o_y_value       (out_y),
        .o_saturated     (out_sat),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    spmv_row_checker row_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_func          (in_func),
        .i_column_index  (in_column),
        .i_operand_value (in_operand),
        .i_prior_y       (in_prior),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_row_number    (out_row),
        .i_y_value       (out_y),
        .i_saturated     (out_sat),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_rows_pending  (rows_pending)
    );

    // Watchdog: abandon the run once nothing has moved for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Idle length: three weighted ranges, now and then a long pause.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            idle_len = $urandom_range(1, 3);
        else if (r < 95)
            idle_len = $urandom_range(4, 12);
        else
            idle_len = $urandom_range(20, 60);
    endfunction

    // Q16.16 operand: mostly small magnitudes so that sums stay meaningful,
    // with full-range values and both extremes mixed in.
    function automatic logic [spmv_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pick_value = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            4, 5, 6:    pick_value = $urandom;
            7:          pick_value = VAL_MAX;
            8:          pick_value = VAL_MIN;
            default:    pick_value = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    // Random column in the full index range.
    function automatic logic [spmv_pkg::COL_W-1:0] pick_col();
        pick_col = 10'($urandom_range(0, spmv_pkg::X_DEPTH - 1));
    endfunction

    // Result side: stall at random, with calm stretches of constant ready.
    initial begin
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 79) == 0) rx_calm = ~rx_calm;
            if (steady || rx_calm) begin
                out_ready = 1'b1;
            end else if (rx_wait > 0) begin
                out_ready = 1'b0;
                rx_wait--;
            end else begin
                out_ready = 1'b1;
                if ($urandom_range(0, 3) == 0) rx_wait = idle_len();
            end
        end
    end

    // Present one item and hold it until taken. Enter and leave on a falling edge;
    // valid is left high on exit so that a following item can go out back to back.
    task automatic send_item(input logic [spmv_pkg::FUNC_W-1:0] func,
                             input logic [spmv_pkg::COL_W-1:0] col,
                             input logic [spmv_pkg::VAL_W-1:0] operand,
                             input logic [spmv_pkg::VAL_W-1:0] prior);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_calm = ~tx_calm;
        gap = (steady || tx_calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_func    = func;
        in_column  = col;
        in_operand = operand;
        in_prior   = prior;
        in_valid   = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Load an x entry and note it as safe to read.
    task automatic load_x(input logic [spmv_pkg::COL_W-1:0] col,
                          input logic [spmv_pkg::VAL_W-1:0] value);
        send_item(spmv_pkg::FUNC_LOAD, col, value, pick_value());
        if (!x_known[col]) begin
            x_known[col] = 1'b1;
            known_cols.push_back(int'(col));
        end
    endtask

    // Drop valid, wait for every row result, then let in-flight nonzeros settle.
    task automatic drain_rows();
        in_valid = 1'b0;
        while (rows_pending != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(input logic [spmv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [spmv_pkg::VAL_W-1:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random rows: nonzeros on loaded columns only, each row closed, with
    // x reloads between and inside rows and the odd spare-code item as noise.
    task automatic run_rows(input int quota);
        int sent;
        int nnz;
        int k;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 4) == 0) begin
                load_x(pick_col(), pick_value());
                sent++;
            end
            nnz = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
            for (k = 0; k < nnz; k++) begin
                if ($urandom_range(0, 29) == 0)
                    send_item(FUNC_SPARE, pick_col(), $urandom, $urandom);
                if ($urandom_range(0, 19) == 0) begin
                    load_x(pick_col(), pick_value());
                    sent++;
                end
                send_item(spmv_pkg::FUNC_NZ,
                          10'(known_cols[$urandom_range(0, known_cols.size() - 1)]),
                          pick_value(), $urandom);
                sent++;
            end
            send_item(spmv_pkg::FUNC_CLOSE, pick_col(), $urandom, pick_value());
            sent++;
        end
    endtask

    initial begin
        int burst;
        foreach (x_known[i]) x_known[i] = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Plain dot product with the reset scale: extremes, rounding, clipping.
        load_x(10'd0, VAL_MAX);
        load_x(10'd1023, VAL_MIN);
        load_x(10'd1, Q_ONE);
        load_x(10'd3, Q_HALF);
        send_item(spmv_pkg::FUNC_CLOSE, '0, '0, VAL_MAX);          // empty row gives zero
        send_item(spmv_pkg::FUNC_NZ, 10'd1, 32'h0001_8000, '0);
        send_item(spmv_pkg::FUNC_CLOSE, '0, '0, '0);
        send_item(spmv_pkg::FUNC_NZ, 10'd3, 32'h0000_0001, '0);    // exactly half an LSB
        send_item(spmv_pkg::FUNC_CLOSE, '0, '0, '0);
        send_item(spmv_pkg::FUNC_NZ, 10'd3, 32'hFFFF_FFFF, '0);    // negative half
        send_item(spmv_pkg::FUNC_CLOSE, '0, '0, '0);
        repeat (3) send_item(spmv_pkg::FUNC_NZ, 10'd0, VAL_MAX, '0);    // clips high
        send_item(spmv_pkg::FUNC_CLOSE, '0, '0, '0);
        repeat (3) send_item(spmv_pkg::FUNC_NZ, 10'd1023, VAL_MAX, '0); // clips low
        send_item(spmv_pkg::FUNC_CLOSE, '0, '0, '0);
        send_item(FUNC_SPARE, 10'h3FF, VAL_MAX, VAL_MIN);
        send_item(spmv_pkg::FUNC_NZ, 10'd1023, VAL_MIN, '0);       // only the result clips
        send_item(spmv_pkg::FUNC_CLOSE, '0, '0, '0);
        drain_rows();

        // Accumulate mode with the largest scale.
        write_reg(spmv_pkg::CFG_MODE, 32'd1);
        write_reg(spmv_pkg::CFG_SCALE, VAL_MAX);
        send_item(spmv_pkg::FUNC_CLOSE, '0, '0, VAL_MAX);
        send_item(spmv_pkg::FUNC_NZ, 10'd1, Q_ONE, '0);
        send_item(spmv_pkg::FUNC_CLOSE, '0, '0, VAL_MAX);          // prior plus scaled sum clips
        send_item(spmv_pkg::FUNC_CLOSE, '0, '0, VAL_MIN);
        send_item(spmv_pkg::FUNC_NZ, 10'd3, 32'h0000_0001, '0);
        send_item(spmv_pkg::FUNC_CLOSE, '0, '0, '0);

        repeat (24) load_x(pick_col(), pick_value());
        run_rows(60);
        drain_rows();
        write_reg(spmv_pkg::CFG_SCALE, VAL_MIN);
        run_rows(60);
        drain_rows();
        write_reg(spmv_pkg::CFG_SCALE, '0);
        run_rows(50);
        drain_rows();
        write_reg(spmv_pkg::CFG_SCALE, Q_ONE);
        run_rows(60);
        drain_rows();
        write_reg(spmv_pkg::CFG_SCALE, 32'hFFFF_8000);
        run_rows(60);
        drain_rows();
        write_reg(spmv_pkg::CFG_SCALE, $urandom);
        run_rows(60);
        drain_rows();
        write_reg(spmv_pkg::CFG_MODE, 32'd0);
        run_rows(70);
        drain_rows();

        // Close empty rows back to back with no idling on either side.
        write_reg(spmv_pkg::CFG_MODE, 32'd1);
        steady = 1'b1;
        burst = 20;
        repeat (burst) send_item(spmv_pkg::FUNC_CLOSE, pick_col(), $urandom, $urandom);
        steady = 1'b0;
        drain_rows();
        write_reg(spmv_pkg::CFG_MODE, 32'd0);
        run_rows(50);

        in_valid = 1'b0;
        while (rows_pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
